FILE: hw/rtl/fema_pkg.sv
package fema_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CNT_W = COUNT_BITS + 1;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(1) << COUNT_BITS;

    typedef struct packed {
        logic signed [31:0] error_value;
        logic signed [31:0] actual_value;
        logic               last_item;
    } t_in_item;

    typedef struct packed {
        logic [30:0]        mean_abs_error;
        logic [30:0]        root_mean_sq_error;
        logic signed [31:0] mean_bias;
        logic [30:0]        largest_abs_error;
        logic [31:0]        mean_pct_error;
        logic               pct_valid;
        logic [30:0]        error_spread;
        logic [16:0]        run_count;
    } t_out_item;

endpackage

FILE: hw/rtl/fema_if.sv
interface fema_in_if (input logic i_clk);
    logic               valid;
    logic               ready;
    fema_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fema_out_if (input logic i_clk);
    logic                valid;
    logic                ready;
    fema_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/fema_divsqrt.sv
// shared radix-2 divider / floor square root, one quotient or root bit per cycle
module fema_divsqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_sqrt,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic [63:0] r_num, r_den, r_quot, n_rem_d;
    logic [64:0] r_rem, n_rem;
    logic [6:0]  r_cnt;
    logic        r_busy, r_sqrt;
    logic [65:0] s_trial, s_tri;
    logic [64:0] s_shift;

    always_comb begin
        // restoring division: rem = rem*2 + next bit
        s_shift = {r_rem[63:0], r_num[63]};
        // sqrt: rem = rem*4 + next two bits, trial = 4*root+1
        s_tri   = {r_rem[63:0], r_num[63:62]};
        s_trial = {r_quot, 2'b01};
        n_rem   = r_rem;
        n_rem_d = r_quot;
        if (r_sqrt) begin
            if (s_tri >= s_trial) begin
                n_rem   = 65'(s_tri - s_trial);
                n_rem_d = {r_quot[62:0], 1'b1};
            end else begin
                n_rem   = s_tri[64:0];
                n_rem_d = {r_quot[62:0], 1'b0};
            end
        end else begin
            if (s_shift >= {1'b0, r_den}) begin
                n_rem   = s_shift - {1'b0, r_den};
                n_rem_d = {r_quot[62:0], 1'b1};
            end else begin
                n_rem   = s_shift;
                n_rem_d = {r_quot[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_sqrt <= i_sqrt;
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
            r_cnt  <= i_sqrt ? 7'd32 : 7'd64;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_rem_d;
            r_num  <= r_sqrt ? {r_num[61:0], 2'b00} : {r_num[62:0], 1'b0};
            r_cnt  <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    assign o_quot = r_quot;
    // o_quot valid in the cycle o_done is high is the registered quotient
endmodule

FILE: hw/rtl/forecast_error_metrics_accumulator.sv
// Forecast error metrics accumulator. One residual per item (error and actual,
// signed Q16.16, plus a last mark); a last item yields one result item with MAE,
// RMSE, bias, peak error, MAPE, error spread and count, then clears the sums.
// All divides and square roots run one bit per cycle on one shared radix-2
// unit: an item with nonzero actual runs one 64-step divide before the next
// accept, an item with zero actual none; a last item adds four 64-step divides
// and two 32-step roots, plus any wait for the previous result item to leave
// the output register. The input is not blocked by a waiting result until the
// next last item needs the register. The squared error and the squared bias
// each use a 32x32 multiply.
module forecast_error_metrics_accumulator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fema_in_if.sink       i_item,
    fema_out_if.source    o_item
);
    localparam logic [3:0] ST_IDLE = 4'd0, ST_ACC = 4'd1, ST_RATIO = 4'd2,
        ST_MAE = 4'd3, ST_MSQ = 4'd4, ST_BIAS = 4'd5, ST_PCT = 4'd6,
        ST_RMS = 4'd7, ST_VAR = 4'd8, ST_OUT = 4'd9, ST_WAITDIV = 4'd10;

    logic [3:0]  r_state, r_next_after;
    logic [47:0] r_abs_sum, r_signed_sum_u, r_ratio_sum;
    logic [63:0] r_square_sum, r_sq, r_msq;
    logic [30:0] r_peak;
    logic [fema_pkg::CNT_W-1:0] r_items, r_ratio_items;
    logic [31:0] r_me, r_ma;
    logic        r_last, r_out_valid, r_neg, r_start, r_sqrt;
    logic [63:0] r_num, r_den;
    logic signed [31:0] r_bias;
    logic [31:0] r_bmag;
    fema_pkg::t_out_item r_out;

    logic        s_done;
    logic [63:0] s_quot;

    fema_divsqrt u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start), .i_sqrt(r_sqrt),
        .i_num(r_num), .i_den(r_den), .o_done(s_done), .o_quot(s_quot)
    );

    // magnitudes are exact, so -2^31 gives 2^31
    logic [31:0] s_me, s_ma;
    assign s_me = i_item.payload.error_value[31] ? 32'(-i_item.payload.error_value)
                                                 : 32'(i_item.payload.error_value);
    assign s_ma = i_item.payload.actual_value[31] ? 32'(-i_item.payload.actual_value)
                                                  : 32'(i_item.payload.actual_value);

    assign i_item.ready   = (r_state == ST_IDLE);
    assign o_item.valid   = r_out_valid;
    assign o_item.payload = r_out;

    logic [48:0] s_abs_add, s_ratio_add;
    logic [64:0] s_sq_add;
    logic signed [48:0] s_ss_add;
    logic [63:0] s_b2;
    assign s_abs_add   = {1'b0, r_abs_sum} + 49'(r_me);
    assign s_sq_add    = {1'b0, r_square_sum} + {1'b0, r_sq};
    assign s_ss_add    = $signed({r_signed_sum_u[47], r_signed_sum_u})
                       + 49'($signed({r_neg, r_neg ? 32'(-r_me) : r_me}));
    assign s_ratio_add = {1'b0, r_ratio_sum}
                       + 49'((s_quot[63:32] != 0) ? 32'hFFFF_FFFF : s_quot[31:0]);
    assign s_b2        = r_bmag * r_bmag;

    always_ff @(posedge i_clk) begin
        r_start <= 1'b0;
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_out_valid <= 1'b0;
            r_abs_sum <= '0; r_square_sum <= '0; r_signed_sum_u <= '0;
            r_peak <= '0; r_ratio_sum <= '0; r_items <= '0; r_ratio_items <= '0;
        end else begin
            if (o_item.valid && o_item.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (i_item.valid && i_item.ready) begin
                    r_me   <= s_me;
                    r_ma   <= s_ma;
                    r_neg  <= i_item.payload.error_value[31];
                    r_last <= i_item.payload.last_item;
                    r_sq   <= s_me * s_me;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_abs_sum <= s_abs_add[48] ? '1 : s_abs_add[47:0];
                    r_square_sum <= s_sq_add[64] ? '1 : s_sq_add[63:0];
                    if (s_ss_add[48] != s_ss_add[47])
                        r_signed_sum_u <= s_ss_add[48] ? 48'h8000_0000_0000
                                                       : 48'h7FFF_FFFF_FFFF;
                    else r_signed_sum_u <= s_ss_add[47:0];
                    if ({1'b0, (r_me[31] ? 31'h7FFF_FFFF : r_me[30:0])} > {1'b0, r_peak})
                        r_peak <= r_me[31] ? 31'h7FFF_FFFF : r_me[30:0];
                    if (r_items < fema_pkg::COUNT_CAP) r_items <= r_items + 1'b1;
                    if (r_ma != 0) begin
                        if (r_ratio_items < fema_pkg::COUNT_CAP)
                            r_ratio_items <= r_ratio_items + 1'b1;
                        r_num <= {16'd0, r_me, 16'd0}; r_den <= {32'd0, r_ma};
                        r_sqrt <= 1'b0; r_start <= 1'b1;
                        r_next_after <= ST_RATIO; r_state <= ST_WAITDIV;
                    end else r_state <= ST_RATIO;
                end
                ST_WAITDIV: if (s_done) r_state <= r_next_after;
                ST_RATIO: begin
                    if (r_ma != 0) r_ratio_sum <= s_ratio_add[48] ? '1 : s_ratio_add[47:0];
                    if (!r_last) r_state <= ST_IDLE;
                    else begin
                        r_num <= {16'd0, r_abs_sum};
                        r_den <= 64'(r_items); r_sqrt <= 1'b0; r_start <= 1'b1;
                        r_next_after <= ST_MAE; r_state <= ST_WAITDIV;
                    end
                end
                // hold here until the previous result item has left
                ST_MAE: if (!r_out_valid) begin
                    r_out.mean_abs_error <= (s_quot[63:31] != 0) ? 31'h7FFF_FFFF
                                                                : s_quot[30:0];
                    r_num <= r_square_sum; r_den <= 64'(r_items); r_start <= 1'b1;
                    r_next_after <= ST_MSQ; r_state <= ST_WAITDIV;
                end
                ST_MSQ: begin
                    r_msq <= s_quot;
                    // divide the magnitude, truncation toward zero
                    r_num <= {16'd0, r_signed_sum_u[47] ? 48'(-r_signed_sum_u)
                                                        : r_signed_sum_u};
                    r_den <= 64'(r_items); r_start <= 1'b1;
                    r_next_after <= ST_BIAS; r_state <= ST_WAITDIV;
                end
                ST_BIAS: begin
                    if (r_signed_sum_u[47]) begin
                        r_bias <= (s_quot > 64'h8000_0000) ? 32'sh8000_0000
                                                           : 32'(-s_quot[31:0]);
                        r_bmag <= (s_quot > 64'h8000_0000) ? 32'h8000_0000 : s_quot[31:0];
                    end else begin
                        r_bias <= (s_quot > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                           : 32'(s_quot[31:0]);
                        r_bmag <= (s_quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : s_quot[31:0];
                    end
                    r_num <= 64'(r_ratio_sum) * 64'd100;
                    r_den <= (r_ratio_items != 0) ? 64'(r_ratio_items) : 64'd1;
                    r_start <= 1'b1;
                    r_next_after <= ST_PCT; r_state <= ST_WAITDIV;
                end
                ST_PCT: begin
                    r_out.pct_valid <= (r_ratio_items != 0);
                    r_out.mean_pct_error <= (r_ratio_items == 0) ? 32'd0
                        : (s_quot[63:32] != 0) ? 32'hFFFF_FFFF : s_quot[31:0];
                    r_num <= r_msq; r_sqrt <= 1'b1; r_start <= 1'b1;
                    r_next_after <= ST_RMS; r_state <= ST_WAITDIV;
                end
                ST_RMS: begin
                    r_out.root_mean_sq_error <= s_quot[31] ? 31'h7FFF_FFFF : s_quot[30:0];
                    r_num <= (r_msq > s_b2) ? r_msq - s_b2 : 64'd0;
                    r_sqrt <= 1'b1; r_start <= 1'b1;
                    r_next_after <= ST_VAR; r_state <= ST_WAITDIV;
                end
                ST_VAR: begin
                    r_out.error_spread <= s_quot[31] ? 31'h7FFF_FFFF : s_quot[30:0];
                    r_out.mean_bias <= r_bias;
                    r_out.largest_abs_error <= r_peak;
                    r_out.run_count <= 17'(r_items);
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    r_out_valid <= 1'b1;
                    r_abs_sum <= '0; r_square_sum <= '0; r_signed_sum_u <= '0;
                    r_peak <= '0; r_ratio_sum <= '0; r_items <= '0;
                    r_ratio_items <= '0;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_item.ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_item.valid && !o_item.ready) |=> o_item.valid) else $error("result dropped");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_items <= fema_pkg::COUNT_CAP) else $error("count overflow");
endmodule
